// File: rtl/bse_pkg.sv
// bse_pkg: payload types and fixed constants for the bubble sort engine.
// No dependencies. The sort module and the top level use it.
package bse_pkg;

    localparam int unsigned VAL_W = 32;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    is_last;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] sorted_value;
        logic                    is_final;
        logic                    overflowed;
    } t_out_item;

endpackage

// File: rtl/bse_sort.sv
// bse_sort: value buffer memory plus the load / sort-pass / readout sequencer.
// Depends on bse_pkg. Results leave as one-cycle pulses into the top-level output register.
module bse_sort #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  bse_pkg::t_in_item   i_in_data,
    output logic                o_in_stall,
    input  logic                i_res_free,
    output logic                o_res_valid,
    output bse_pkg::t_out_item  o_res_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_START = 6'b000010,
        S_FIRST = 6'b000100,
        S_PASS  = 6'b001000,
        S_END   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    logic signed [bse_pkg::VAL_W-1:0] mem [DEPTH];
    logic signed [bse_pkg::VAL_W-1:0] r_rd_data;

    t_state                           r_state, n_state;
    logic [CW-1:0]                    r_count, n_count;
    logic                             r_drop, n_drop;
    logic                             r_swap, n_swap;
    logic [AW-1:0]                    r_idx, n_idx;
    logic signed [bse_pkg::VAL_W-1:0] r_carry, n_carry;
    logic                             r_pend, n_pend;
    logic                             r_fin, n_fin;

    logic                             we;
    logic [AW-1:0]                    waddr;
    logic signed [bse_pkg::VAL_W-1:0] wdata;
    logic [AW-1:0]                    raddr;
    logic                             room;
    logic [CW-1:0]                    cnt_after;
    logic [AW-1:0]                    last_idx;
    logic                             issue;

    assign room      = r_count < CW'(DEPTH);
    assign cnt_after = room ? (r_count + CW'(1)) : r_count;
    assign last_idx  = AW'(r_count - CW'(1));
    assign issue     = (r_state == S_OUT) && !r_pend && i_res_free;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_drop  = r_drop;
        n_swap  = r_swap;
        n_idx   = r_idx;
        n_carry = r_carry;
        n_pend  = 1'b0;
        n_fin   = r_fin;
        we      = 1'b0;
        waddr   = r_count[AW-1:0];
        wdata   = i_in_data.value;
        raddr   = r_idx;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    if (room) begin
                        we      = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_in_data.is_last) begin
                        n_idx   = '0;
                        n_state = (cnt_after < CW'(2)) ? S_OUT : S_START;
                    end
                end
            end
            S_START: begin
                raddr   = '0;
                n_swap  = 1'b0;
                n_state = S_FIRST;
            end
            S_FIRST: begin
                n_carry = r_rd_data;
                raddr   = AW'(1);
                n_idx   = AW'(1);
                n_state = S_PASS;
            end
            S_PASS: begin
                // carry holds the larger value bubbling up; the smaller one settles at idx-1
                we    = 1'b1;
                waddr = r_idx - AW'(1);
                if (r_carry > r_rd_data) begin
                    wdata  = r_rd_data;
                    n_swap = 1'b1;
                end else begin
                    wdata   = r_carry;
                    n_carry = r_rd_data;
                end
                if (r_idx == last_idx) begin
                    n_state = S_END;
                end else begin
                    raddr = r_idx + AW'(1);
                    n_idx = r_idx + AW'(1);
                end
            end
            S_END: begin
                we    = 1'b1;
                waddr = last_idx;
                wdata = r_carry;
                n_idx = '0;
                n_state = r_swap ? S_START : S_OUT;
            end
            S_OUT: begin
                if (issue) begin
                    n_pend = 1'b1;
                    n_fin  = (r_idx == last_idx);
                    n_idx  = r_idx + AW'(1);
                end
                if (r_pend && r_fin) begin
                    n_state = S_LOAD;
                    n_count = '0;
                    n_drop  = 1'b0;
                    n_swap  = 1'b0;
                    n_idx   = '0;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_data <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_swap  <= 1'b0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
            r_swap  <= n_swap;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_fin   <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
    end

    assign o_in_stall               = (r_state != S_LOAD);
    assign o_res_valid              = r_pend;
    assign o_res_data.sorted_value  = r_rd_data;
    assign o_res_data.is_final      = r_fin;
    assign o_res_data.overflowed    = r_drop;

endmodule

// File: rtl/bubble_sort_engine_core.sv
// Load: one value per cycle; input stalls from the item marked last until the final result
// enters the output register. Sort: each pass over n values does one memory read and one
// write per cycle, repeated until a pass makes no swap, at most n passes. Readout: a result
// is fetched only once the previous one has passed on and the output register is free.
// Reset is synchronous, active low; it clears control state only, not the value memory.
// bubble_sort_engine_core: top level; output register over bse_sort. Depends on bse_pkg.
module bubble_sort_engine_core #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  bse_pkg::t_in_item   i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bse_pkg::t_out_item  o_out_data
);

    logic               res_valid;
    bse_pkg::t_out_item res_data;
    logic               res_free;
    logic               r_out_valid;
    bse_pkg::t_out_item r_out_data;

    assign res_free = !r_out_valid || !i_out_stall;

    bse_sort #(
        .DEPTH (DEPTH)
    ) u_sort (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_res_free  (res_free),
        .o_res_valid (res_valid),
        .o_res_data  (res_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_data <= res_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a result from the memory only lands in an empty output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !r_out_valid)
        else $error("result overwrote a pending transfer");

    // nothing follows the final result of a set in the next cycle
    a_final_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.is_final) |=> !o_out_valid)
        else $error("result directly after final transfer");

    // input is held off while a result is being fetched
    a_stall_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> o_in_stall)
        else $error("input accepted during readout");

endmodule

// File: sim/bubble_sort_engine_core_tb.sv
// Self-checking testbench for bubble_sort_engine_core: random value sets in, sorted sets out.
// Needs bse_pkg and the core RTL; a scoreboard class predicts each sorted set.
module bubble_sort_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 245;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 40;

    class sort_scoreboard;
        logic signed [bse_pkg::VAL_W-1:0] held_vals[DEPTH];
        int                 held_count;
        bit                 lost_any;
        bse_pkg::t_out_item expected_sorted[$];
        int                 mismatches;

        function new();
            held_count = 0;
            lost_any   = 0;
            mismatches = 0;
        endfunction

        function void note_value(bse_pkg::t_in_item item);
            logic signed [bse_pkg::VAL_W-1:0] key;
            int                               j;
            bse_pkg::t_out_item               res;
            if (held_count < DEPTH) begin
                held_vals[held_count] = item.value;
                held_count++;
            end else begin
                lost_any = 1'b1;
            end
            if (!item.is_last) return;
            for (int i = 1; i < held_count; i++) begin
                key = held_vals[i];
                j = i - 1;
                while (j >= 0 && held_vals[j] > key) begin
                    held_vals[j + 1] = held_vals[j];
                    j--;
                end
                held_vals[j + 1] = key;
            end
            for (int k = 0; k < held_count; k++) begin
                res.sorted_value = held_vals[k];
                res.is_final     = (k == held_count - 1);
                res.overflowed   = lost_any;
                expected_sorted.push_back(res);
            end
            held_count = 0;
            lost_any   = 1'b0;
        endfunction

        function void check_sorted(bse_pkg::t_out_item got);
            bse_pkg::t_out_item want;
            if (expected_sorted.size() == 0) begin
                $error("unexpected result: sorted_value %0d", got.sorted_value);
                mismatches++;
                return;
            end
            want = expected_sorted.pop_front();
            if (got.sorted_value !== want.sorted_value) begin
                $error("sorted_value expected %0d actual %0d", want.sorted_value,
                       got.sorted_value);
                mismatches++;
            end
            if (got.is_final !== want.is_final) begin
                $error("is_final expected %0b actual %0b", want.is_final, got.is_final);
                mismatches++;
            end
            if (got.overflowed !== want.overflowed) begin
                $error("overflowed expected %0b actual %0b", want.overflowed, got.overflowed);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_sorted.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    bse_pkg::t_in_item  in_data;
    logic               in_stall;
    logic               out_valid;
    logic               out_stall;
    bse_pkg::t_out_item out_data;

    sort_scoreboard board;
    int  idle_cycles;
    int  results_seen;
    bit  steady_in;

    bubble_sort_engine_core #(.DEPTH(DEPTH)) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [bse_pkg::VAL_W-1:0] pick_value(int style);
        case (style)
            0: return $urandom_range(0, 6) - 3;
            1: begin
                case ($urandom_range(0, 5))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sh0000_0000;
                    3: return -32'sd1;
                    4: return 32'sh8000_0001;
                    default: return 32'sh7fff_fffe;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    task automatic send_value(logic signed [bse_pkg::VAL_W-1:0] v, bit last);
        int gap;
        gap = pick_gap(steady_in);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid        <= 1'b1;
        in_data.value   <= v;
        in_data.is_last <= last;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_set(int len, int style);
        for (int i = 0; i < len; i++) send_value(pick_value(style), i == len - 1);
    endtask

    // transfer monitors
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) board.note_value(in_data);
            if (out_valid && !out_stall) begin
                board.check_sorted(out_data);
                results_seen <= results_seen + 1;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off to back the block up
    initial begin
        int  n;
        bit  held;
        held = 1'b0;
        @(posedge rst_n);
        forever begin
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end else if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(20, 60)) begin
                    @(negedge clk);
                    out_stall <= 1'b0;
                end
            end else begin
                n = pick_gap(1'b0);
                repeat (n) begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
            @(negedge clk);
            out_stall <= 1'b0;
        end
    end

    initial begin
        int sent;
        int len;
        int r;
        board        = new();
        idle_cycles  = 0;
        results_seen = 0;
        steady_in    = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_stall    = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_value(32'sd5, 1'b1);
        send_value(32'sh7fff_ffff, 1'b0);
        send_value(32'sh8000_0000, 1'b0);
        send_value(-32'sd1, 1'b0);
        send_value(32'sd0, 1'b0);
        send_value(32'sd1, 1'b1);
        send_value(-32'sd7, 1'b0);
        send_value(-32'sd7, 1'b0);
        send_value(-32'sd7, 1'b1);
        // one past capacity: the closing value itself is dropped
        for (int i = 0; i <= DEPTH; i++) send_value(DEPTH - i, i == DEPTH);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            steady_in = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 70) len = $urandom_range(1, 5);
            else if (r < 88) len = $urandom_range(6, DEPTH);
            else len = $urandom_range(DEPTH + 1, DEPTH + 4);
            send_set(len, $urandom_range(0, 3));
            sent += len;
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
